FILE: sv/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

  // Item kinds carried on the func field
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_REPLY = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd0;
  localparam logic [2:0] CFG_RETRY_MS      = 3'd1;
  localparam logic [2:0] CFG_RTT_SCALE     = 3'd2;
  localparam logic [2:0] CFG_ECHO_IDENT    = 3'd3;
  localparam logic [2:0] CFG_MAX_SERIES    = 3'd4;

  // Configuration reset values
  localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd100000;
  localparam logic [15:0] RETRY_MS_RST      = 16'd1000;
  localparam logic [9:0]  RTT_SCALE_RST     = 10'd15;
  localparam logic [15:0] ECHO_IDENT_RST    = 16'h1337;
  localparam logic [7:0]  MAX_SERIES_RST    = 8'd16;

  // Saturation limits of the round trip statistics
  localparam logic [39:0] RTT_MAX_VAL = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MAX_VAL = 48'hFFFF_FFFF_FFFF;

  // Per-item flags and totals that travel down the pipeline
  typedef struct packed {
    logic        send_now;
    logic [15:0] send_seq;
    logic        reply_matched;
    logic        timed_out;
    logic        series_done;
    logic [31:0] probes_sent;
    logic [31:0] replies_seen;
    logic [31:0] timeouts_seen;
  } flags_t;

endpackage

FILE: sv/ping_probe_scheduler_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    func, probe_count, reply_seq,
//                                                 reply_ident, now_ms
// out       output     out_valid_o / out_ready_i  send_now ... rtt_total
// cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One transaction per cycle is accepted while stage 0 is not stalled; a result passes stages 0 to 3 in turn.
// Stage 0 registers the input and updates the probe schedule, stage 1 holds
// the elapsed ticks, stage 2 the tick x scale product, stage 3 the result and
// the RTT statistics. Each stage stalls only while the next one is full and
// blocked. Reset (rst_ni low) clears the valids, schedule and statistics and loads the register defaults.

module ping_probe_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  probe_count_i,
  input  logic [15:0] reply_seq_i,
  input  logic [15:0] reply_ident_i,
  input  logic [31:0] now_ms_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_now_o,
  output logic [15:0] send_seq_o,
  output logic        reply_matched_o,
  output logic [39:0] rtt_us_o,
  output logic        timed_out_o,
  output logic        series_done_o,
  output logic [31:0] probes_sent_o,
  output logic [31:0] replies_seen_o,
  output logic [31:0] timeouts_seen_o,
  output logic [39:0] rtt_min_o,
  output logic [39:0] rtt_max_o,
  output logic [47:0] rtt_total_o
);

  // configuration registers
  logic [31:0] timeout_ticks_q;
  logic [15:0] retry_ms_q;
  logic [9:0]  rtt_scale_q;
  logic [15:0] echo_ident_q;
  logic [7:0]  max_series_q;

  // stage valids and readiness
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  // stage 0 input register
  logic [1:0]  func_q;
  logic [7:0]  count_q;
  logic [15:0] rseq_q;
  logic [15:0] rid_q;
  logic [31:0] now_q;

  // schedule state
  logic [31:0] tick_count_q, tick_count_d;
  logic [31:0] sent_tick_q, sent_tick_d;
  logic [31:0] next_send_q, next_send_d;
  logic [7:0]  probes_left_q, probes_left_d;
  logic        awaiting_q, awaiting_d;
  logic [15:0] awaited_seq_q, awaited_seq_d;
  logic [15:0] last_seq_q, last_seq_d;
  logic [31:0] sent_total_q, sent_total_d;
  logic [31:0] reply_total_q, reply_total_d;
  logic [31:0] timeout_total_q, timeout_total_d;

  // stage 0 combinational results
  pps_pkg::flags_t flags0;
  logic [31:0] loops0;
  logic [31:0] elapsed;
  logic [31:0] tick_inc;
  logic [31:0] passed;
  logic [31:0] sched_time;
  logic [7:0]  count_min1;
  logic [7:0]  count_clamped;
  logic [15:0] seq_inc;
  logic [15:0] seq_new;
  logic        do_send;

  // later stages
  pps_pkg::flags_t flags1_q, flags2_q, flags3_q;
  logic [31:0] loops1_q;
  logic [41:0] prod2_q;
  logic [39:0] rtt_sat;
  logic [39:0] rtt_q;
  logic [48:0] sum_ext;
  logic [47:0] sum_sat;
  logic [39:0] rtt_min_q, rtt_max_q;
  logic [47:0] rtt_total_q;

  // ready chain: a stage moves when empty or when its successor moves
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_ready_o = rdy0;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= pps_pkg::TIMEOUT_TICKS_RST;
      retry_ms_q      <= pps_pkg::RETRY_MS_RST;
      rtt_scale_q     <= pps_pkg::RTT_SCALE_RST;
      echo_ident_q    <= pps_pkg::ECHO_IDENT_RST;
      max_series_q    <= pps_pkg::MAX_SERIES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pps_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i;
        pps_pkg::CFG_RETRY_MS:      retry_ms_q      <= cfg_data_i[15:0];
        pps_pkg::CFG_RTT_SCALE:     rtt_scale_q     <= cfg_data_i[9:0];
        pps_pkg::CFG_ECHO_IDENT:    echo_ident_q    <= cfg_data_i[15:0];
        pps_pkg::CFG_MAX_SERIES:    max_series_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      func_q  <= func_i;
      count_q <= probe_count_i;
      rseq_q  <= reply_seq_i;
      rid_q   <= reply_ident_i;
      now_q   <= now_ms_i;
    end
  end

  // shared arithmetic of the schedule
  assign tick_inc      = tick_count_q + 32'd1;
  assign elapsed       = tick_count_q - sent_tick_q;
  assign passed        = tick_inc - sent_tick_q;
  assign sched_time    = now_q + {16'd0, retry_ms_q};
  assign count_min1    = (count_q == 8'd0) ? 8'd1 : count_q;
  assign count_clamped = (count_min1 > max_series_q) ? max_series_q : count_min1;
  assign seq_inc       = last_seq_q + 16'd1;
  assign seq_new       = (seq_inc == 16'd0) ? 16'd1 : seq_inc;

  // update the schedule for the item in stage 0
  always_comb begin
    tick_count_d    = tick_count_q;
    sent_tick_d     = sent_tick_q;
    next_send_d     = next_send_q;
    probes_left_d   = probes_left_q;
    awaiting_d      = awaiting_q;
    awaited_seq_d   = awaited_seq_q;
    last_seq_d      = last_seq_q;
    sent_total_d    = sent_total_q;
    reply_total_d   = reply_total_q;
    timeout_total_d = timeout_total_q;
    flags0          = '0;
    loops0          = 32'd0;
    do_send         = 1'b0;

    unique case (func_q)
      pps_pkg::FUNC_TICK: begin
        tick_count_d = tick_inc;
        if (awaiting_q && (passed >= timeout_ticks_q)) begin
          awaiting_d         = 1'b0;
          timeout_total_d    = timeout_total_q + 32'd1;
          flags0.timed_out   = 1'b1;
          if (probes_left_q != 8'd0) begin
            next_send_d = sched_time;
          end else begin
            flags0.series_done = 1'b1;
          end
        end
        do_send = !awaiting_d && (probes_left_d != 8'd0) &&
                  ((next_send_d == 32'd0) || (now_q >= next_send_d));
      end
      pps_pkg::FUNC_START: begin
        probes_left_d = count_clamped;
        awaiting_d    = 1'b0;
        next_send_d   = 32'd0;
        do_send       = (count_clamped != 8'd0);
      end
      pps_pkg::FUNC_REPLY: begin
        if ((rid_q == echo_ident_q) && awaiting_q && (rseq_q == awaited_seq_q)) begin
          flags0.reply_matched = 1'b1;
          loops0               = (elapsed == 32'd0) ? 32'd1 : elapsed;
          awaiting_d           = 1'b0;
          reply_total_d        = reply_total_q + 32'd1;
          if (probes_left_q != 8'd0) begin
            next_send_d = sched_time;
          end else begin
            flags0.series_done = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // issue the next probe
    if (do_send) begin
      next_send_d     = 32'd0;
      probes_left_d   = probes_left_d - 8'd1;
      last_seq_d      = seq_new;
      awaited_seq_d   = seq_new;
      sent_tick_d     = tick_count_d;
      awaiting_d      = 1'b1;
      sent_total_d    = sent_total_q + 32'd1;
      flags0.send_now = 1'b1;
      flags0.send_seq = seq_new;
    end

    flags0.probes_sent   = sent_total_d;
    flags0.replies_seen  = reply_total_d;
    flags0.timeouts_seen = timeout_total_d;
  end

  // commit the schedule as the item leaves stage 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q    <= 32'd0;
      sent_tick_q     <= 32'd0;
      next_send_q     <= 32'd0;
      probes_left_q   <= 8'd0;
      awaiting_q      <= 1'b0;
      awaited_seq_q   <= 16'd0;
      last_seq_q      <= 16'd0;
      sent_total_q    <= 32'd0;
      reply_total_q   <= 32'd0;
      timeout_total_q <= 32'd0;
    end else if (v0_q && rdy1) begin
      tick_count_q    <= tick_count_d;
      sent_tick_q     <= sent_tick_d;
      next_send_q     <= next_send_d;
      probes_left_q   <= probes_left_d;
      awaiting_q      <= awaiting_d;
      awaited_seq_q   <= awaited_seq_d;
      last_seq_q      <= last_seq_d;
      sent_total_q    <= sent_total_d;
      reply_total_q   <= reply_total_d;
      timeout_total_q <= timeout_total_d;
    end
  end

  // advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // move payload: elapsed ticks, then the scaled product
  always_ff @(posedge clk_i) begin
    if (v0_q && rdy1) begin
      flags1_q <= flags0;
      loops1_q <= loops0;
    end
    if (v1_q && rdy2) begin
      flags2_q <= flags1_q;
      prod2_q  <= 42'(loops1_q) * 42'(rtt_scale_q);
    end
    if (v2_q && rdy3) begin
      flags3_q <= flags2_q;
      rtt_q    <= flags2_q.reply_matched ? rtt_sat : 40'd0;
    end
  end

  // saturate the round trip time and the running sum
  assign rtt_sat = (prod2_q[41:40] != 2'b00) ? pps_pkg::RTT_MAX_VAL : prod2_q[39:0];
  assign sum_ext = {1'b0, rtt_total_q} + {9'd0, rtt_sat};
  assign sum_sat = (sum_ext[48] || (sum_ext[47:0] > pps_pkg::SUM_MAX_VAL)) ?
                   pps_pkg::SUM_MAX_VAL : sum_ext[47:0];

  // record statistics as a matched reply enters the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_min_q   <= 40'd0;
      rtt_max_q   <= 40'd0;
      rtt_total_q <= 48'd0;
    end else if (v2_q && rdy3 && flags2_q.reply_matched) begin
      rtt_total_q <= sum_sat;
      if ((rtt_min_q == 40'd0) || (rtt_sat < rtt_min_q)) begin
        rtt_min_q <= rtt_sat;
      end
      if (rtt_sat > rtt_max_q) begin
        rtt_max_q <= rtt_sat;
      end
    end
  end

  // drive the result
  assign out_valid_o     = v3_q;
  assign send_now_o      = flags3_q.send_now;
  assign send_seq_o      = flags3_q.send_seq;
  assign reply_matched_o = flags3_q.reply_matched;
  assign rtt_us_o        = rtt_q;
  assign timed_out_o     = flags3_q.timed_out;
  assign series_done_o   = flags3_q.series_done;
  assign probes_sent_o   = flags3_q.probes_sent;
  assign replies_seen_o  = flags3_q.replies_seen;
  assign timeouts_seen_o = flags3_q.timeouts_seen;
  assign rtt_min_o       = rtt_min_q;
  assign rtt_max_o       = rtt_max_q;
  assign rtt_total_o     = rtt_total_q;

endmodule
